// ===== src/mrwt_pkg.sv =====
// Package for the Miller-Rabin witness test block.
// Holds widths, the controller state type, the multiply op type and the command and status structs; no dependencies.
package mrwt_pkg;
    localparam int NUM_WIDTH = 32;
    localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);
    localparam int PROD_WIDTH = 2 * NUM_WIDTH;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SHIFT,
        ST_REDUCE,
        ST_POW_STEP,
        ST_POW_WAIT,
        ST_SQ_START,
        ST_SQ_WAIT,
        ST_SQ_CHECK,
        ST_OUT
    } mrwt_state_t;

    typedef enum logic [1:0] {
        MM_REDUCE,   // base mod n
        MM_ACC,      // acc * b mod n
        MM_BSQ,      // b * b mod n
        MM_XSQ       // x * x mod n
    } mrwt_mm_op_t;

    typedef struct packed {
        logic        load;
        logic        shift_u;
        logic        mm_start;
        mrwt_mm_op_t mm_op;
        logic        exp_advance;
        logic        sq_commit;
        logic        cnt_dec;
    } mrwt_cmd_t;

    typedef struct packed {
        logic n_is_two;
        logic n_trivial;
        logic u_even;
        logic exp_zero;
        logic exp_bit;
        logic mm_busy;
        logic mm_done;
        logic cnt_zero;
        logic sq_witness;
        logic x_is_one;
    } mrwt_status_t;
endpackage

// ===== src/miller_rabin_witness_test_top.sv =====
// Top level of the Miller-Rabin witness test: stream ports, output register.
// Depends on mrwt_pkg, mrwt_ctrl, mrwt_datapath.
//
// channel | direction | tdata                          | tuser
// s_      | in        | [31:0] candidate, [63:32] base | -
// m_      | out       | [0] probably_prime             | [0] trivial_case
//
// One item at a time. Trivial candidates skip the multiplies; others take
// one reduction of the base plus one or two modular multiplies per bit of
// u (up to 2*NUM_WIDTH-1 in all), then up to t squarings, all in the
// bit-serial reduction unit.
// Reset clears control state only. A finished result waits in the controller
// until the result register is empty or drains in the same cycle.
module miller_rabin_witness_test_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] candidate, [63:32] base
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] probably_prime, rest zero
    output logic [0:0]  m_tuser    // [0] trivial_case
);
    localparam int NW = mrwt_pkg::NUM_WIDTH;

    mrwt_pkg::mrwt_cmd_t    cmd;
    mrwt_pkg::mrwt_status_t status;
    logic idle, res_load, res_prime, res_trivial, in_fire;
    logic valid_reg, prime_reg, triv_reg;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && idle;

    mrwt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .out_busy    (valid_reg && !m_tready),
        .status      (status),
        .cmd         (cmd),
        .idle        (idle),
        .res_load    (res_load),
        .res_prime   (res_prime),
        .res_trivial (res_trivial)
    );

    mrwt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cand_in (s_tdata[NW-1:0]),
        .base_in (s_tdata[32 +: NW]),
        .cmd     (cmd),
        .status  (status)
    );

    always_ff @(posedge aclk) begin
        if (res_load) begin
            prime_reg <= res_prime;
            triv_reg  <= res_trivial;
        end
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'b0, prime_reg};
    assign m_tuser  = triv_reg;
endmodule

// ===== src/mrwt_modmul.sv =====
// Iterative modular multiply: (a * b) mod m, one product bit per cycle.
// Uses mrwt_pkg for widths.
module mrwt_modmul (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [mrwt_pkg::PROD_WIDTH-1:0]  product,
    input  logic [mrwt_pkg::NUM_WIDTH-1:0]   modulus,
    output logic                             busy,
    output logic                             done,
    output logic [mrwt_pkg::NUM_WIDTH-1:0]   result
);
    localparam int PW = mrwt_pkg::PROD_WIDTH;
    localparam int NW = mrwt_pkg::NUM_WIDTH;
    localparam int IW = $clog2(PW + 1);

    logic [PW-1:0] prod_reg, prod_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW:0]   trial;

    // shift in one product bit, subtract modulus when it fits
    always_comb begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, prod_reg[PW-1]};
        if (start) begin
            prod_next = product;
            rem_next  = '0;
            cnt_next  = IW'(PW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            prod_next = {prod_reg[PW-2:0], 1'b0};
            if (trial >= {1'b0, modulus}) begin
                rem_next = NW'(trial - {1'b0, modulus});
            end else begin
                rem_next = trial[NW-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == IW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = rem_reg;
endmodule

// ===== src/mrwt_datapath.sv =====
// Datapath: operand registers, exponent scan, square counter and one
// product register feeding mrwt_modmul. Depends on mrwt_pkg, mrwt_modmul.
module mrwt_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [mrwt_pkg::NUM_WIDTH-1:0]  cand_in,
    input  logic [mrwt_pkg::NUM_WIDTH-1:0]  base_in,
    input  mrwt_pkg::mrwt_cmd_t             cmd,
    output mrwt_pkg::mrwt_status_t          status
);
    localparam int NW = mrwt_pkg::NUM_WIDTH;
    localparam int PW = mrwt_pkg::PROD_WIDTH;
    localparam int CW = mrwt_pkg::CNT_WIDTH;

    logic [NW-1:0] n_reg, u_reg, b_reg, acc_reg, x_prev_reg;
    logic [CW-1:0] t_reg;
    logic [PW-1:0] prod_reg, prod_next;
    logic [NW-1:0] mm_result;
    logic          mm_busy, mm_done;
    logic [NW-1:0] n_minus1;
    logic          started_reg;
    mrwt_pkg::mrwt_mm_op_t mm_op_reg;

    assign n_minus1 = n_reg - NW'(1);

    // multiply in its own register stage before the reduction unit
    always_comb begin
        unique case (cmd.mm_op)
            mrwt_pkg::MM_REDUCE: prod_next = PW'(b_reg);
            mrwt_pkg::MM_ACC:    prod_next = acc_reg * b_reg;
            mrwt_pkg::MM_BSQ:    prod_next = b_reg * b_reg;
            mrwt_pkg::MM_XSQ:    prod_next = acc_reg * acc_reg;
            default:             prod_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg   <= cand_in;
            u_reg   <= cand_in - NW'(1);
            b_reg   <= base_in;
            acc_reg <= NW'(1);
            t_reg   <= '0;
        end else begin
            if (cmd.shift_u) begin
                u_reg <= {1'b0, u_reg[NW-1:1]};
                t_reg <= t_reg + CW'(1);
            end
            if (cmd.exp_advance) begin
                u_reg <= {1'b0, u_reg[NW-1:1]};
            end
            if (cmd.cnt_dec) begin
                t_reg <= t_reg - CW'(1);
            end
            // write back by the operation that was started
            if (mm_done) begin
                unique case (mm_op_reg)
                    mrwt_pkg::MM_REDUCE: b_reg <= mm_result;
                    mrwt_pkg::MM_ACC:    acc_reg <= mm_result;
                    mrwt_pkg::MM_BSQ:    b_reg <= mm_result;
                    mrwt_pkg::MM_XSQ:    x_prev_reg <= mm_result;
                    default:             b_reg <= b_reg;
                endcase
            end
            if (cmd.sq_commit) begin
                acc_reg <= x_prev_reg;
            end
        end
        if (cmd.mm_start) begin
            prod_reg  <= prod_next;
            mm_op_reg <= cmd.mm_op;
        end
    end

    // mm_start is registered into started_reg, which starts the unit on the captured product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
        end else begin
            started_reg <= cmd.mm_start;
        end
    end

    mrwt_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (started_reg),
        .product (prod_reg),
        .modulus (n_reg),
        .busy    (mm_busy),
        .done    (mm_done),
        .result  (mm_result)
    );

    assign status.n_is_two   = (n_reg == NW'(2));
    assign status.n_trivial  = (n_reg == NW'(1)) || !n_reg[0];
    assign status.u_even     = !u_reg[0];
    assign status.exp_zero   = (u_reg == '0);
    assign status.exp_bit    = u_reg[0];
    assign status.mm_busy    = mm_busy || started_reg;
    assign status.mm_done    = mm_done;
    assign status.cnt_zero   = (t_reg == '0);
    // new square is 1 while the squared value was neither 1 nor n-1
    assign status.sq_witness = (x_prev_reg == NW'(1)) && (acc_reg != NW'(1))
                               && (acc_reg != n_minus1);
    assign status.x_is_one   = (acc_reg == NW'(1));
endmodule

// ===== src/mrwt_ctrl.sv =====
// Controller state machine for the witness test.
// Depends on mrwt_pkg; drives mrwt_datapath by command struct.
module mrwt_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_fire,
    input  logic                    out_busy,
    input  mrwt_pkg::mrwt_status_t  status,
    output mrwt_pkg::mrwt_cmd_t     cmd,
    output logic                    idle,
    output logic                    res_load,
    output logic                    res_prime,
    output logic                    res_trivial
);
    mrwt_pkg::mrwt_state_t state_reg, state_next;
    mrwt_pkg::mrwt_mm_op_t op_reg, op_next;
    logic                  prime_reg, prime_next;
    logic                  triv_reg, triv_next;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        prime_next = prime_reg;
        triv_next  = triv_reg;
        cmd        = '0;
        cmd.mm_op  = op_reg;
        idle       = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            mrwt_pkg::ST_IDLE: begin
                idle = 1'b1;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = mrwt_pkg::ST_CLASSIFY;
                end
            end
            mrwt_pkg::ST_CLASSIFY: begin
                if (status.n_is_two) begin
                    prime_next = 1'b1;
                    triv_next  = 1'b1;
                    state_next = mrwt_pkg::ST_OUT;
                end else if (status.n_trivial) begin
                    prime_next = 1'b0;
                    triv_next  = 1'b1;
                    state_next = mrwt_pkg::ST_OUT;
                end else begin
                    triv_next  = 1'b0;
                    state_next = mrwt_pkg::ST_SHIFT;
                end
            end
            mrwt_pkg::ST_SHIFT: begin
                // strip factors of two from n-1
                if (status.u_even) begin
                    cmd.shift_u = 1'b1;
                end else begin
                    op_next      = mrwt_pkg::MM_REDUCE;
                    cmd.mm_op    = mrwt_pkg::MM_REDUCE;
                    cmd.mm_start = 1'b1;
                    state_next   = mrwt_pkg::ST_REDUCE;
                end
            end
            mrwt_pkg::ST_REDUCE: begin
                if (status.mm_done) begin
                    state_next = mrwt_pkg::ST_POW_STEP;
                end
            end
            mrwt_pkg::ST_POW_STEP: begin
                if (status.exp_zero) begin
                    state_next = mrwt_pkg::ST_SQ_START;
                end else begin
                    op_next    = status.exp_bit ? mrwt_pkg::MM_ACC : mrwt_pkg::MM_BSQ;
                    cmd.mm_op  = op_next;
                    cmd.mm_start = 1'b1;
                    state_next = mrwt_pkg::ST_POW_WAIT;
                end
            end
            mrwt_pkg::ST_POW_WAIT: begin
                if (status.mm_done) begin
                    if (op_reg == mrwt_pkg::MM_ACC) begin
                        op_next      = mrwt_pkg::MM_BSQ;
                        cmd.mm_op    = mrwt_pkg::MM_BSQ;
                        cmd.mm_start = 1'b1;
                    end else begin
                        cmd.exp_advance = 1'b1;
                        state_next      = mrwt_pkg::ST_POW_STEP;
                    end
                end
            end
            mrwt_pkg::ST_SQ_START: begin
                if (status.cnt_zero) begin
                    prime_next = status.x_is_one;
                    state_next = mrwt_pkg::ST_OUT;
                end else begin
                    op_next      = mrwt_pkg::MM_XSQ;
                    cmd.mm_op    = mrwt_pkg::MM_XSQ;
                    cmd.mm_start = 1'b1;
                    state_next   = mrwt_pkg::ST_SQ_WAIT;
                end
            end
            mrwt_pkg::ST_SQ_WAIT: begin
                if (status.mm_done) begin
                    state_next = mrwt_pkg::ST_SQ_CHECK;
                end
            end
            mrwt_pkg::ST_SQ_CHECK: begin
                if (status.sq_witness) begin
                    prime_next = 1'b0;
                    state_next = mrwt_pkg::ST_OUT;
                end else begin
                    cmd.sq_commit = 1'b1;
                    cmd.cnt_dec   = 1'b1;
                    state_next    = mrwt_pkg::ST_SQ_START;
                end
            end
            mrwt_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!out_busy) begin
                    res_load   = 1'b1;
                    state_next = mrwt_pkg::ST_IDLE;
                end
            end
            default: state_next = mrwt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        prime_reg <= prime_next;
        triv_reg  <= triv_next;
        if (!aresetn) begin
            state_reg <= mrwt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign res_prime   = prime_reg;
    assign res_trivial = triv_reg;
endmodule
